// ----- src/tmcg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the text-mode character generator.
package tmcg_pkg;

    localparam int TEXT_COLUMNS_DEF    = 40;
    localparam int TEXT_CELLS_DEF      = 1000;
    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int GLYPH_LINES         = 8;
    localparam int CELL_PIXELS         = 8;
    localparam int FONT_DEPTH          = 256 * GLYPH_LINES;
    localparam int FONT_AW             = 11;
    localparam int TARGET_W            = 11;
    localparam int QUEUE_DEPTH         = 4;
    localparam int HEIGHT_W            = 9;
    localparam int IN_TDATA_W          = 48;
    localparam int OUT_TDATA_W         = 24;

    localparam logic [HEIGHT_W-1:0] SCREEN_HEIGHT_RESET = 9'd200;
    localparam logic [2:0]          PIX_LAST            = 3'(CELL_PIXELS - 1);

    typedef enum logic [2:0] {
        OP_CHAR_WR = 3'd0,
        OP_FG_WR   = 3'd1,
        OP_BG_WR   = 3'd2,
        OP_PAL_WR  = 3'd3,
        OP_FONT_WR = 3'd4,
        OP_RENDER  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_CELL,
        ST_RD_FG,
        ST_RD_BG,
        ST_LOAD
    } state_t;

    // One queued command: the operation, its data and the glyph line of a render
    typedef struct packed {
        op_t         op;
        logic [15:0] value;
        logic [2:0]  sub;
    } cmd_t;

    function automatic int cell_w(input int cells);
        return (cells > 1) ? $clog2(cells) : 1;
    endfunction

    function automatic int addr_w(input int cells);
        return (cell_w(cells) > TARGET_W) ? cell_w(cells) : TARGET_W;
    endfunction

endpackage

// ----- src/tmcg_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module tmcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ----- src/tmcg_fifo.sv -----
`timescale 1ns / 1ps
// Short command queue between the front and back ends.
module tmcg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tmcg_pkg::QUEUE_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             rd_valid
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr_en)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !rd_valid |-> !rd_en)
        else $error("queue read while empty");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on write");
`endif

endmodule

// ----- src/tmcg_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input items, holds screen height, classifies and range-checks.
module tmcg_front #(
    parameter int TEXT_COLUMNS    = tmcg_pkg::TEXT_COLUMNS_DEF,
    parameter int TEXT_CELLS      = tmcg_pkg::TEXT_CELLS_DEF,
    parameter int PALETTE_ENTRIES = tmcg_pkg::PALETTE_ENTRIES_DEF,
    localparam int ADDR_W = tmcg_pkg::addr_w(TEXT_CELLS)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tmcg_pkg::HEIGHT_W-1:0]      cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tmcg_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic [2:0]                         s_tuser,
    input  logic                               q_full,
    input  logic                               clearing,
    output logic                               push,
    output tmcg_pkg::cmd_t                     push_cmd,
    output logic [ADDR_W-1:0]                  push_addr
);

    logic [tmcg_pkg::HEIGHT_W-1:0] screen_height_reg;
    logic [10:0]                   target;
    logic [15:0]                   value;
    logic [8:0]                    line;
    logic [5:0]                    col;
    logic [5:0]                    row;
    logic [14:0]                   cell_lin;
    logic                          keep;
    tmcg_pkg::op_t                 op;

    assign op     = tmcg_pkg::op_t'(s_tuser);
    assign target = s_tdata[10:0];
    assign value  = s_tdata[26:11];
    assign line   = s_tdata[35:27];
    assign col    = s_tdata[41:36];

    // Glyphs are eight lines high: text row is the upper line bits
    assign row      = line[8:3];
    assign cell_lin = 15'(row) * 15'(TEXT_COLUMNS) + 15'(col);

    always_comb
    begin
        keep      = 1'b0;
        push_addr = ADDR_W'(target);
        unique case (op)
            tmcg_pkg::OP_CHAR_WR,
            tmcg_pkg::OP_FG_WR,
            tmcg_pkg::OP_BG_WR:
            begin
                keep = (32'(target) < TEXT_CELLS);
            end
            tmcg_pkg::OP_PAL_WR:
            begin
                keep = (32'(target) < PALETTE_ENTRIES);
            end
            tmcg_pkg::OP_FONT_WR:
            begin
                keep = 1'b1;
            end
            tmcg_pkg::OP_RENDER:
            begin
                keep      = (line < screen_height_reg) && (32'(col) < TEXT_COLUMNS)
                            && (32'(cell_lin) < TEXT_CELLS);
                push_addr = ADDR_W'(cell_lin);
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push_cmd.op    = op;
    assign push_cmd.value = value;
    assign push_cmd.sub   = line[2:0];

    // Hold off items during the clearing pass; dropped items are still taken
    assign s_tready = !q_full && !clearing;
    assign push     = s_tvalid && s_tready && keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_height_reg <= tmcg_pkg::SCREEN_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            screen_height_reg <= cfg_wdata;
        end
    end

endmodule

// ----- src/tmcg_back.sv -----
`timescale 1ns / 1ps
// Back end: owns the stores, executes queued commands and serializes cell pixels.
module tmcg_back #(
    parameter int TEXT_CELLS      = tmcg_pkg::TEXT_CELLS_DEF,
    parameter int PALETTE_ENTRIES = tmcg_pkg::PALETTE_ENTRIES_DEF,
    localparam int CELL_W = tmcg_pkg::cell_w(TEXT_CELLS),
    localparam int ADDR_W = tmcg_pkg::addr_w(TEXT_CELLS),
    localparam int PAL_W  = $clog2(PALETTE_ENTRIES)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             head_valid,
    input  tmcg_pkg::cmd_t                   head_cmd,
    input  logic [ADDR_W-1:0]                head_addr,
    output logic                             pop,
    output logic                             clearing,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tmcg_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                             m_tlast
);

    tmcg_pkg::state_t state_reg, state_next;
    logic [CELL_W-1:0] clr_addr_reg, clr_addr_next;

    logic                       char_we, fg_we, bg_we, pal_we, font_we;
    logic [CELL_W-1:0]          cell_waddr;
    logic [7:0]                 cell_wdata;
    logic [7:0]                 char_rdata, fg_rdata, bg_rdata, font_rdata;
    logic [15:0]                pal_rdata;
    logic [PAL_W-1:0]           pal_raddr;
    logic [tmcg_pkg::FONT_AW-1:0] font_raddr;

    logic [PALETTE_ENTRIES-1:0] pal_valid_reg;
    logic [2:0]                 sub_reg;
    logic [7:0]                 fg_idx_reg, bg_idx_reg;
    logic [7:0]                 glyph_reg;
    logic [15:0]                fg_color_reg, bg_color_reg;
    logic [15:0]                pal_color;
    logic [7:0]                 pal_idx;

    logic                       load;
    logic                       pix_free;
    logic                       pix_hs;
    logic                       pix_busy_reg;
    logic [2:0]                 pix_cnt_reg;
    logic [7:0]                 pix_glyph_reg;
    logic [15:0]                pix_fg_reg, pix_bg_reg;
    logic [15:0]                pix_color;

    tmcg_ram #(.WIDTH(8), .DEPTH(TEXT_CELLS)) u_char_ram (
        .clk(clk), .we(char_we), .waddr(cell_waddr), .wdata(cell_wdata),
        .raddr(head_addr[CELL_W-1:0]), .rdata(char_rdata)
    );
    tmcg_ram #(.WIDTH(8), .DEPTH(TEXT_CELLS)) u_fg_ram (
        .clk(clk), .we(fg_we), .waddr(cell_waddr), .wdata(cell_wdata),
        .raddr(head_addr[CELL_W-1:0]), .rdata(fg_rdata)
    );
    tmcg_ram #(.WIDTH(8), .DEPTH(TEXT_CELLS)) u_bg_ram (
        .clk(clk), .we(bg_we), .waddr(cell_waddr), .wdata(cell_wdata),
        .raddr(head_addr[CELL_W-1:0]), .rdata(bg_rdata)
    );
    tmcg_ram #(.WIDTH(16), .DEPTH(PALETTE_ENTRIES)) u_pal_ram (
        .clk(clk), .we(pal_we), .waddr(head_addr[PAL_W-1:0]), .wdata(head_cmd.value),
        .raddr(pal_raddr), .rdata(pal_rdata)
    );
    tmcg_ram #(.WIDTH(8), .DEPTH(tmcg_pkg::FONT_DEPTH)) u_font_ram (
        .clk(clk), .we(font_we), .waddr(head_addr[tmcg_pkg::FONT_AW-1:0]),
        .wdata(head_cmd.value[7:0]), .raddr(font_raddr), .rdata(font_rdata)
    );

    // Glyph line address is char code times eight plus sub line
    assign font_raddr = {char_rdata, sub_reg};

    assign pix_hs   = pix_busy_reg && m_tready;
    assign pix_free = !pix_busy_reg || (pix_hs && (pix_cnt_reg == tmcg_pkg::PIX_LAST));

    // Next state
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            tmcg_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == CELL_W'(TEXT_CELLS - 1))
                begin
                    state_next = tmcg_pkg::ST_IDLE;
                end
            end
            tmcg_pkg::ST_IDLE:
            begin
                if (head_valid && (head_cmd.op == tmcg_pkg::OP_RENDER))
                begin
                    state_next = tmcg_pkg::ST_RD_CELL;
                end
            end
            tmcg_pkg::ST_RD_CELL: state_next = tmcg_pkg::ST_RD_FG;
            tmcg_pkg::ST_RD_FG:   state_next = tmcg_pkg::ST_RD_BG;
            tmcg_pkg::ST_RD_BG:   state_next = tmcg_pkg::ST_LOAD;
            tmcg_pkg::ST_LOAD:
            begin
                if (pix_free)
                begin
                    state_next = tmcg_pkg::ST_IDLE;
                end
            end
            default: state_next = tmcg_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        pop        = 1'b0;
        clearing   = 1'b0;
        char_we    = 1'b0;
        fg_we      = 1'b0;
        bg_we      = 1'b0;
        pal_we     = 1'b0;
        font_we    = 1'b0;
        load       = 1'b0;
        cell_waddr = head_addr[CELL_W-1:0];
        cell_wdata = head_cmd.value[7:0];
        pal_raddr  = fg_rdata[PAL_W-1:0];
        unique case (state_reg)
            tmcg_pkg::ST_CLEAR:
            begin
                clearing   = 1'b1;
                char_we    = 1'b1;
                fg_we      = 1'b1;
                bg_we      = 1'b1;
                cell_waddr = clr_addr_reg;
                cell_wdata = '0;
            end
            tmcg_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    unique case (head_cmd.op)
                        tmcg_pkg::OP_CHAR_WR: char_we = 1'b1;
                        tmcg_pkg::OP_FG_WR:   fg_we   = 1'b1;
                        tmcg_pkg::OP_BG_WR:   bg_we   = 1'b1;
                        tmcg_pkg::OP_PAL_WR:  pal_we  = 1'b1;
                        tmcg_pkg::OP_FONT_WR: font_we = 1'b1;
                        default:              pop     = 1'b1;
                    endcase
                end
            end
            tmcg_pkg::ST_RD_CELL: pal_raddr = fg_rdata[PAL_W-1:0];
            tmcg_pkg::ST_RD_FG:   pal_raddr = bg_idx_reg[PAL_W-1:0];
            tmcg_pkg::ST_RD_BG:   pal_raddr = bg_idx_reg[PAL_W-1:0];
            tmcg_pkg::ST_LOAD:    load      = pix_free;
            default:              pop       = 1'b0;
        endcase
    end

    // Out-of-range or never-written palette entries read as zero
    assign pal_idx   = (state_reg == tmcg_pkg::ST_RD_FG) ? fg_idx_reg : bg_idx_reg;
    assign pal_color = ((9'(pal_idx) < 9'(PALETTE_ENTRIES)) && pal_valid_reg[pal_idx[PAL_W-1:0]])
                       ? pal_rdata : 16'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tmcg_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            pal_valid_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            if (pal_we)
            begin
                pal_valid_reg[head_addr[PAL_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == tmcg_pkg::ST_IDLE)
        begin
            sub_reg <= head_cmd.sub;
        end
        if (state_reg == tmcg_pkg::ST_RD_CELL)
        begin
            fg_idx_reg <= fg_rdata;
            bg_idx_reg <= bg_rdata;
        end
        if (state_reg == tmcg_pkg::ST_RD_FG)
        begin
            glyph_reg    <= font_rdata;
            fg_color_reg <= pal_color;
        end
        if (state_reg == tmcg_pkg::ST_RD_BG)
        begin
            bg_color_reg <= pal_color;
        end
        if (load)
        begin
            pix_glyph_reg <= glyph_reg;
            pix_fg_reg    <= fg_color_reg;
            pix_bg_reg    <= bg_color_reg;
        end
    end

    // Pixel serializer: one pixel per handshake, MSB of the glyph line first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_busy_reg <= 1'b0;
            pix_cnt_reg  <= '0;
        end
        else if (load)
        begin
            pix_busy_reg <= 1'b1;
            pix_cnt_reg  <= '0;
        end
        else if (pix_hs)
        begin
            if (pix_cnt_reg == tmcg_pkg::PIX_LAST)
            begin
                pix_busy_reg <= 1'b0;
            end
            pix_cnt_reg <= pix_cnt_reg + 1'b1;
        end
    end

    assign pix_color = pix_glyph_reg[tmcg_pkg::PIX_LAST - pix_cnt_reg] ? pix_fg_reg : pix_bg_reg;
    assign m_tvalid  = pix_busy_reg;
    assign m_tdata   = {5'b0, pix_cnt_reg, pix_color};
    assign m_tlast   = (pix_cnt_reg == tmcg_pkg::PIX_LAST);

`ifndef ASSERT_OFF
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tmcg_pkg::ST_CLEAR) |-> !pop)
        else $error("command taken during clearing pass");
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> pix_free)
        else $error("serializer loaded while a cell is still going out");
    a_busy_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_hs && (pix_cnt_reg == tmcg_pkg::PIX_LAST) && !load) |=> !pix_busy_reg)
        else $error("serializer still busy after last pixel");
    a_fetch_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tmcg_pkg::ST_RD_CELL) |=> (state_reg == tmcg_pkg::ST_RD_FG))
        else $error("render fetch sequence broken");
`endif

endmodule

// ----- src/text_mode_character_generator_top.sv -----
`timescale 1ns / 1ps
// Top level of the text-mode character generator.
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tuser: operation; tdata: target_index, write_value,
//                                  raster_line, column
// m_*      out  m_tvalid/m_tready  tdata: pixel_color, pixel_offset; tlast: last
// cfg_*    in   cfg_we             cfg_wdata: screen_height
//
// A write item passes the queue and is executed by the back end in its idle state. A
// render item passes the states IDLE, RD_CELL, RD_FG, RD_BG and LOAD to fetch (cell
// RAMs, then font and palette RAMs, the single palette read port visited twice), then
// goes out as eight pixels, one per handshake; fetch overlaps output, so the next cell
// is fetched while the current one goes out. After reset a clearing pass zeroes the
// cell stores; s_tready stays low meanwhile. A stalled m_tready holds the current
// pixel; the queue then fills and s_tready drops.
module text_mode_character_generator_top #(
    parameter int TEXT_COLUMNS    = tmcg_pkg::TEXT_COLUMNS_DEF,
    parameter int TEXT_CELLS      = tmcg_pkg::TEXT_CELLS_DEF,
    parameter int PALETTE_ENTRIES = tmcg_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tmcg_pkg::HEIGHT_W-1:0]    cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // target_index[10:0], write_value[26:11], raster_line[35:27], column[41:36]
    input  logic [tmcg_pkg::IN_TDATA_W-1:0]  s_tdata,
    // operation[2:0]
    input  logic [2:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pixel_color[15:0], pixel_offset[18:16]
    output logic [tmcg_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                             m_tlast
);

    localparam int ADDR_W = tmcg_pkg::addr_w(TEXT_CELLS);
    localparam int Q_W    = $bits(tmcg_pkg::cmd_t) + ADDR_W;

    logic              push, pop, q_full, head_valid, clearing;
    tmcg_pkg::cmd_t    push_cmd, head_cmd;
    logic [ADDR_W-1:0] push_addr, head_addr;
    logic [Q_W-1:0]    head_word;

    tmcg_front #(
        .TEXT_COLUMNS(TEXT_COLUMNS),
        .TEXT_CELLS(TEXT_CELLS),
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .q_full(q_full), .clearing(clearing),
        .push(push), .push_cmd(push_cmd), .push_addr(push_addr)
    );

    tmcg_fifo #(.WIDTH(Q_W), .DEPTH(tmcg_pkg::QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_en(push), .wr_data({push_addr, push_cmd}), .full(q_full),
        .rd_en(pop), .rd_data(head_word), .rd_valid(head_valid)
    );

    assign head_cmd  = tmcg_pkg::cmd_t'(head_word[$bits(tmcg_pkg::cmd_t)-1:0]);
    assign head_addr = head_word[Q_W-1:$bits(tmcg_pkg::cmd_t)];

    tmcg_back #(
        .TEXT_CELLS(TEXT_CELLS),
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .head_valid(head_valid), .head_cmd(head_cmd), .head_addr(head_addr),
        .pop(pop), .clearing(clearing),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

endmodule
